### sv/b64p_pkg.sv
// ============================================================================
// b64p_pkg - shared types and constants of the base64 PCM16 sample decoder
// Status codes, sextet lookup result and the per-character result bundle.
// ============================================================================
`default_nettype none

package b64p_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic KindSample = 1'b0;
  localparam logic KindEnd    = 1'b1;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StBadChar = 3'd1,
    StBadPad  = 3'd2,
    StBadLen  = 3'd3,
    StOdd     = 3'd4
  } b64p_status_e;

  // one character looked up in the standard alphabet
  typedef struct packed {
    logic [5:0] value;  // all ones for a character outside the alphabet
    logic       bad;
    logic       pad;
  } b64p_sextet_t;

  // everything one character produces: up to two samples and an end status
  typedef struct packed {
    logic [1:0]         n_samp;
    logic signed [15:0] samp0;
    logic signed [15:0] samp1;
    logic               has_end;
    b64p_status_e       status;
  } b64p_bundle_t;

endpackage

`default_nettype wire

### sv/b64p_ifs.sv
// ============================================================================
// b64p_ifs - stream interfaces of the base64 PCM16 sample decoder
// Character request channel and result request channel, valid/ready.
// ============================================================================
`default_nettype none

interface b64p_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink   (input valid, input character, input is_last, output ready);
endinterface

interface b64p_res_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] sample;
  logic [2:0]         status;
  logic               last;

  modport source (output valid, output kind, output sample, output status, output last,
                  input ready);
  modport sink   (input valid, input kind, input sample, input status, input last,
                  output ready);
endinterface

`default_nettype wire

### sv/b64p_sextet_decode.sv
// ============================================================================
// b64p_sextet_decode - standard base64 alphabet lookup
// Maps one character to its six-bit value and flags pad and bad characters.
// ============================================================================
`default_nettype none

module b64p_sextet_decode
  import b64p_pkg::*;
(
  input  logic [7:0]   chr_i,
  output b64p_sextet_t sextet_o
);

  logic [7:0] upper_off;
  logic [7:0] lower_off;
  logic [7:0] digit_off;

  assign upper_off = chr_i - 8'h41;
  assign lower_off = chr_i - 8'h47;  // 'a' maps to 26
  assign digit_off = chr_i + 8'h04;  // '0' maps to 52

  always_comb begin
    sextet_o.pad = (chr_i == PadChar);
    sextet_o.bad = 1'b0;
    unique case (chr_i) inside
      [8'h41:8'h5A]: sextet_o.value = upper_off[5:0];
      [8'h61:8'h7A]: sextet_o.value = lower_off[5:0];
      [8'h30:8'h39]: sextet_o.value = digit_off[5:0];
      8'h2B:         sextet_o.value = 6'd62;
      8'h2F:         sextet_o.value = 6'd63;
      default: begin
        sextet_o.value = 6'h3F;
        sextet_o.bad   = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/b64p_group_unit.sv
// ============================================================================
// b64p_group_unit - group assembly, padding checks and sample pairing
// Holds the decode state and builds the result bundle of each character.
// ============================================================================
`default_nettype none

module b64p_group_unit
  import b64p_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   chr_i,
  input  logic         is_last_i,
  output b64p_bundle_t bundle_o,
  output logic         load_o
);

  b64p_sextet_t sx;

  logic [1:0]   pos_q, pos_d;
  logic [17:0]  acc_q, acc_d;
  logic         twp_q, twp_d;
  logic [7:0]   pb_q, pb_d;
  logic         pv_q, pv_d;
  b64p_status_e err_q, err_d;

  logic [23:0]  bits;
  logic [31:0]  seq;
  logic [1:0]   n_bytes;
  logic [2:0]   tot;
  logic         bad_pad;

  b64p_sextet_decode u_sextet (
    .chr_i    (chr_i),
    .sextet_o (sx)
  );

  function automatic b64p_status_e first_err(b64p_status_e cur, b64p_status_e code);
    return (cur == StOk) ? code : cur;
  endfunction

  assign bits    = {acc_q, (sx.pad ? 6'd0 : sx.value)};
  assign bad_pad = (twp_q && !sx.pad) || (!is_last_i && (twp_q || sx.pad));

  always_comb begin
    pos_d    = pos_q + 2'd1;
    acc_d    = acc_q;
    twp_d    = twp_q;
    pb_d     = pb_q;
    pv_d     = pv_q;
    err_d    = err_q;
    n_bytes  = 2'd0;
    seq      = '0;
    tot      = 3'd0;
    bundle_o = '0;
    bundle_o.status = StOk;

    case (pos_q) inside
      2'd0, 2'd1: begin
        if (sx.pad) begin
          err_d = first_err(err_q, StBadPad);
        end else if (sx.bad) begin
          err_d = first_err(err_q, StBadChar);
        end
        acc_d = {acc_q[11:0], sx.value};
      end
      2'd2: begin
        if (sx.pad) begin
          twp_d = 1'b1;
          acc_d = {acc_q[11:0], 6'd0};
        end else begin
          twp_d = 1'b0;
          if (sx.bad) begin
            err_d = first_err(err_q, StBadChar);
          end
          acc_d = {acc_q[11:0], sx.value};
        end
      end
      default: begin
        // padding is judged before the alphabet test of the fourth character
        if (bad_pad) begin
          err_d = first_err(err_q, StBadPad);
        end else if (!sx.pad && sx.bad) begin
          err_d = first_err(err_q, StBadChar);
        end
        if (err_d == StOk) begin
          n_bytes = 2'd1 + 2'(!twp_q) + 2'(!sx.pad);
          seq = pv_q ? {bits[7:0], bits[15:8], bits[23:16], pb_q}
                     : {8'd0, bits[7:0], bits[15:8], bits[23:16]};
          tot = {2'b00, pv_q} + {1'b0, n_bytes};
          bundle_o.n_samp = tot[2:1];
          bundle_o.samp0  = seq[15:0];
          bundle_o.samp1  = seq[31:16];
          pv_d = tot[0];
          pb_d = (tot == 3'd1) ? seq[7:0] : seq[23:16];
        end
        acc_d = '0;
        twp_d = 1'b0;
      end
    endcase

    if (is_last_i) begin
      bundle_o.has_end = 1'b1;
      if (pos_q != 2'd3) begin
        bundle_o.status = StBadLen;
      end else if (err_d != StOk) begin
        bundle_o.status = err_d;
      end else if (pv_d) begin
        bundle_o.status = StOdd;
      end else begin
        bundle_o.status = StOk;
      end
      pos_d = '0;
      acc_d = '0;
      twp_d = 1'b0;
      pb_d  = '0;
      pv_d  = 1'b0;
      err_d = StOk;
    end
  end

  assign load_o = accept_i && ((bundle_o.n_samp != 2'd0) || bundle_o.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
      twp_q <= 1'b0;
      pb_q  <= '0;
      pv_q  <= 1'b0;
      err_q <= StOk;
    end else if (accept_i) begin
      pos_q <= pos_d;
      acc_q <= acc_d;
      twp_q <= twp_d;
      pb_q  <= pb_d;
      pv_q  <= pv_d;
      err_q <= err_d;
    end
  end

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_last_i |=> (pos_q == 2'd0) && (err_q == StOk) && !pv_q)
    else $error("state not cleared after end of message");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !is_last_i && (err_q != StOk) |=> err_q == $past(err_q))
    else $error("first error overwritten");

  a_no_samp_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (err_q != StOk) |-> bundle_o.n_samp == 2'd0)
    else $error("sample produced after an error");
`endif

endmodule

`default_nettype wire

### sv/b64p_out_stage.sv
// ============================================================================
// b64p_out_stage - result register and serializer
// Holds a character's bundle, hands out its results one per cycle while ready.
// ============================================================================
`default_nettype none

module b64p_out_stage
  import b64p_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  b64p_bundle_t bundle_i,
  output logic         in_ready_o,
  b64p_res_if.source   res_o
);

  b64p_bundle_t bundle_q;
  logic         valid_q;
  logic [1:0]   idx_q;
  logic [1:0]   total;
  logic         cur_last;
  logic         is_samp;
  logic         take;

  assign total    = bundle_q.n_samp + 2'(bundle_q.has_end);
  assign cur_last = (idx_q == total - 2'd1);
  assign is_samp  = (idx_q < bundle_q.n_samp);
  assign take     = valid_q && res_o.ready;

  // take a new bundle when empty or when the final result leaves this cycle
  assign in_ready_o = !valid_q || (res_o.ready && cur_last);

  assign res_o.valid  = valid_q;
  assign res_o.kind   = is_samp ? KindSample : KindEnd;
  assign res_o.sample = is_samp ? (idx_q[0] ? bundle_q.samp1 : bundle_q.samp0) : 16'sd0;
  assign res_o.status = is_samp ? StOk : bundle_q.status;
  assign res_o.last   = cur_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (cur_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> idx_q < total)
    else $error("result index past bundle");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q && (idx_q == 2'd0))
    else $error("bundle load lost");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !cur_last |=> valid_q && (idx_q == $past(idx_q) + 2'd1))
    else $error("result skipped or dropped");
`endif

endmodule

`default_nettype wire

### sv/base64_pcm16_sample_decoder_core.sv
// ============================================================================
// base64_pcm16_sample_decoder_core - streaming base64 to PCM16 decoder
// Decodes base64 text one character per request into little-endian signed
// 16-bit samples (Q1.15) and ends each message with a status result.
// ============================================================================
//
//   channel  dir  payload                          request taken when
//   -------  ---  -------------------------------  --------------------
//   char_i   in   character[7:0], is_last          valid && ready
//   res_o    out  kind, sample[15:0], status, last valid && ready
//
// One character request is taken per cycle while char_i is ready; the fourth
// character of a group yields up to two sample results and the final one adds
// one status. The result register empties one result per cycle while res_o
// is ready, so a bundle of n results holds it until its last result is taken;
// characters with no result do not load it. The serializer sets throughput.
// Reset clears the decode state and empties the result register.
// A stalled result holds; ready on char_i drops only while a bundle waits.
// ============================================================================
`default_nettype none

module base64_pcm16_sample_decoder_core
  import b64p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  b64p_char_if.sink  char_i,
  b64p_res_if.source res_o
);

  b64p_bundle_t bundle;
  logic         load;
  logic         in_ready;
  logic         accept;

  // a character is consumed at once: state advances on the accepting edge
  assign char_i.ready = in_ready;
  assign accept       = char_i.valid && in_ready;

  // decode state and per-character bundle
  b64p_group_unit u_group (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .chr_i     (char_i.character),
    .is_last_i (char_i.is_last),
    .bundle_o  (bundle),
    .load_o    (load)
  );

  // result register; advance one result per taken request
  b64p_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .bundle_i   (bundle),
    .in_ready_o (in_ready),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire
